>>> hw/rtl/btda_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; imported by btda_dabble_step and the top level.
package btda_pkg;

   localparam int unsigned WordWidth  = 64;
   localparam int unsigned NumDigits  = 20;
   localparam int unsigned BcdWidth   = 4 * NumDigits;
   localparam int unsigned CountWidth = $clog2(WordWidth);
   localparam int unsigned DigitWidth = $clog2(NumDigits + 1);

   localparam logic [7:0] AsciiZero  = 8'd48;
   localparam logic [7:0] AsciiMinus = 8'd45;

   // request payload: raw word and signed/unsigned mode
   typedef struct packed {
      logic [WordWidth-1:0] value;
      logic                 mode;
   } req_type;

   // response payload: one ASCII character and end-of-number flag
   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

endpackage

>>> hw/rtl/btda_dabble_step.sv
// One shift-add-3 (double dabble) step over the full BCD register.
// Depends on btda_pkg for the digit count.
module btda_dabble_step (
   input  logic [btda_pkg::BcdWidth-1:0] bcd,
   input  logic                          shift_in,
   output logic [btda_pkg::BcdWidth-1:0] bcd_next
);
   import btda_pkg::*;

   logic [BcdWidth-1:0] adjusted;

   // add 3 to every digit of 5 or more, digits are independent
   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = bcd[4*i +: 4];
         end
      end
   end

   // shift left, next binary bit enters at the bottom
   assign bcd_next = {adjusted[BcdWidth-2:0], shift_in};

endmodule

>>> hw/rtl/binary_to_decimal_ascii_top.sv
// Binary to decimal ASCII converter, top level.
// Uses btda_pkg and btda_dabble_step.
//
// Usage:
//   A request on req_ (valid/ready) carries a 64-bit value and a mode bit
//   (0 unsigned, 1 two's complement). The block answers with one response
//   per character on rsp_ (valid/ready): an optional '-' and then the
//   decimal digits, most significant first, no leading zeros. The final
//   character carries last = 1. Zero gives the single character '0'.
// Timing:
//   req_ready is high only while the sequencer is idle. After acceptance
//   the shared shift-add-3 unit takes one binary bit per cycle, then
//   leading zero digits are dropped at one digit per cycle (up to 19), then
//   characters go into the output register at one per cycle while the
//   output register is free. Skipped and emitted digits always add up to
//   20, and the next request is taken only after the last character has
//   gone into the output register.
// Reset: synchronous, active high; returns the sequencer to idle and drops
//   any pending response. When rsp_ready is low the output register holds
//   its character and the next character waits; no character is lost.
module binary_to_decimal_ascii_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  btda_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output btda_pkg::rsp_type rsp_data
);
   import btda_pkg::*;

   typedef enum logic [2:0] {
      StIdle,
      StConvert,
      StSkip,
      StSign,
      StEmit
   } state_type;

   state_type             state_ff;
   logic [WordWidth-1:0]  bin_ff;
   logic [BcdWidth-1:0]   bcd_ff;
   logic [CountWidth-1:0] cnt_ff;
   logic [DigitWidth-1:0] dig_ff;
   logic                  neg_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [BcdWidth-1:0]   bcd_in;
   logic                  negative;
   logic                  out_free;
   logic                  emit_now;
   logic                  req_accept;
   logic [3:0]            top_digit;

   assign req_ready  = (state_ff == StIdle);
   assign req_accept = req_valid && req_ready;
   assign negative   = req_data.mode && req_data.value[WordWidth-1];
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emit_now   = out_free && (state_ff == StSign || state_ff == StEmit);
   assign top_digit  = bcd_ff[BcdWidth-1 -: 4];

   // shared conversion unit
   btda_dabble_step u_step (
      .bcd      (bcd_ff),
      .shift_in (bin_ff[WordWidth-1]),
      .bcd_next (bcd_in)
   );

   // sequencer with registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         dig_ff       <= '0;
         neg_ff       <= 1'b0;
      end else begin
         // new character loaded, or old one still waiting
         rsp_valid_ff <= emit_now || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            StIdle: begin
               if (req_accept) begin
                  neg_ff   <= negative;
                  bin_ff   <= negative ? (~req_data.value + 1'b1) : req_data.value;
                  bcd_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= StConvert;
               end
            end
            StConvert: begin
               bcd_ff <= bcd_in;
               bin_ff <= {bin_ff[WordWidth-2:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CountWidth'(WordWidth - 1)) begin
                  dig_ff   <= DigitWidth'(NumDigits);
                  state_ff <= StSkip;
               end
            end
            StSkip: begin
               // drop a leading zero digit, keep at least one
               if (top_digit == 4'd0 && dig_ff != DigitWidth'(1)) begin
                  bcd_ff <= {bcd_ff[BcdWidth-5:0], 4'd0};
                  dig_ff <= dig_ff - 1'b1;
               end else begin
                  state_ff <= neg_ff ? StSign : StEmit;
               end
            end
            StSign: begin
               if (out_free) begin
                  rsp_data_ff.character <= AsciiMinus;
                  rsp_data_ff.last      <= 1'b0;
                  state_ff              <= StEmit;
               end
            end
            StEmit: begin
               if (out_free) begin
                  rsp_data_ff.character <= AsciiZero + {4'd0, top_digit};
                  rsp_data_ff.last      <= (dig_ff == DigitWidth'(1));
                  bcd_ff                <= {bcd_ff[BcdWidth-5:0], 4'd0};
                  dig_ff                <= dig_ff - 1'b1;
                  if (dig_ff == DigitWidth'(1)) begin
                     state_ff <= StIdle;
                  end
               end
            end
            default: begin
               state_ff <= StIdle;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
